[rtl/albl_pkg.sv]
// ----------------------------------------------------------------------------
// albl_pkg - shared types, constants and tables for the backlight level block
// Fixed-point formats, curve constants and the elaboration-time tables for
// log2 of the first level and the exp2 root factors.
// ----------------------------------------------------------------------------
package albl_pkg;

  localparam int LUX_W     = 16;
  localparam int ADJ_FRAC  = 7;
  localparam int ADJ_W     = ADJ_FRAC + 2;
  localparam int NIT_W     = 14;
  localparam int ML_W      = 12;
  localparam int CFG_W     = 14;
  localparam int FRAC_W    = 16;
  localparam int LOG_W     = 20;
  localparam int EXP_W     = 19;
  localparam int ACC_W     = 31;
  localparam int LOG_STEPS = 16;
  localparam int PWR_STEPS = 16;

  localparam logic [0:0] CFG_MAX_NIT   = 1'b0;
  localparam logic [0:0] CFG_MAX_LEVEL = 1'b1;

  localparam logic [NIT_W-1:0] RST_MAX_NIT   = 14'd400;
  localparam logic [ML_W-1:0]  RST_MAX_LEVEL = 12'd255;

  localparam logic [39:0] CURVE_C1 = 40'd451186;
  localparam logic [39:0] CURVE_C0 = 40'd1773339;

  // floor(q / 2000) over q < 512000 is (q >> 4) * RECIP >> RECIP_SH
  localparam logic [30:0] RECIP    = 31'd33555;
  localparam int          RECIP_SH = 22;
  localparam logic [27:0] SAT_Q    = 28'd512000;

  typedef logic [LOG_W-1:0] log_lut_t [256];
  typedef logic [31:0]      ftab_t [PWR_STEPS+1];

  // side data that rides along the log stages
  typedef struct packed {
    logic             byp;
    logic [7:0]       lev;
    logic [EXP_W-1:0] e;
    logic [3:0]       lux_top;
    logic [3:0]       ml_top;
  } side_t;

  // item state through the exp2 product chain
  typedef struct packed {
    logic             byp;
    logic [7:0]       lev;
    logic [6:0]       n;
    logic [15:0]      g;
    logic [ACC_W-1:0] acc;
  } pwr_t;

  function automatic logic [LOG_W-1:0] log2_q16(input logic [15:0] x);
    logic [4:0]  top;
    logic [33:0] m;
    logic [15:0] frac;
    top  = 5'd0;
    frac = 16'd0;
    for (int b = 0; b < 16; b++) begin
      if (x[b]) top = 5'(b);
    end
    m = 34'(x) << (5'd16 - top);
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 16;
      if (m >= 34'h20000) begin
        m = m >> 1;
        frac[i] = 1'b1;
      end
    end
    return {top[3:0], frac};
  endfunction

  function automatic log_lut_t build_log_lut();
    log_lut_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = log2_q16(16'(i));
    end
    return t;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = v_in;
    res = 64'd0;
    bt  = 64'h4000_0000_0000_0000;
    while (bt > v) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic ftab_t build_ftab();
    ftab_t f;
    logic [63:0] r;
    f[0] = 32'h8000_0000;
    for (int k = 1; k <= PWR_STEPS; k++) begin
      r    = isqrt64(64'(f[k-1]) << 30);
      f[k] = r[31:0];
    end
    return f;
  endfunction

  localparam log_lut_t LOG_LUT = build_log_lut();
  localparam ftab_t    FTAB    = build_ftab();

endpackage

[rtl/albl_log2_pipe.sv]
// ----------------------------------------------------------------------------
// albl_log2_pipe - pipelined log2 fraction
// Sixteen registered squaring steps turn a Q1.16 mantissa into 16 fraction bits.
// ----------------------------------------------------------------------------
module albl_log2_pipe (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [albl_pkg::FRAC_W:0]      m_i,
  output logic [albl_pkg::FRAC_W-1:0]    frac_o
);

  logic [albl_pkg::FRAC_W:0]   m_q [albl_pkg::LOG_STEPS];
  logic [albl_pkg::FRAC_W-1:0] f_q [albl_pkg::LOG_STEPS];

  for (genvar k = 0; k < albl_pkg::LOG_STEPS; k++) begin : g_step
    logic [albl_pkg::FRAC_W:0]   m_in;
    logic [albl_pkg::FRAC_W-1:0] f_in;
    logic [33:0]                 sq;
    logic [17:0]                 s;

    if (k == 0) begin : g_first
      assign m_in = m_i;
      assign f_in = '0;
    end else begin : g_next
      assign m_in = m_q[k-1];
      assign f_in = f_q[k-1];
    end

    assign sq = 34'(m_in) * 34'(m_in);
    assign s  = sq[33:16];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // renormalize to [1,2) and record the bit
        if (s[17]) begin
          m_q[k] <= s[17:1];
          f_q[k] <= f_in | (16'd1 << (albl_pkg::LOG_STEPS - 1 - k));
        end else begin
          m_q[k] <= s[16:0];
          f_q[k] <= f_in;
        end
      end
    end
  end

  assign frac_o = f_q[albl_pkg::LOG_STEPS-1];

endmodule

[rtl/ambient_light_backlight_level_top.sv]
// ----------------------------------------------------------------------------
// ambient_light_backlight_level_top - ambient light to backlight level
// Log curve of lux, scale by peak nits, then a gamma step against max_level.
// ----------------------------------------------------------------------------
// One item per cycle while out_stall_i holds no result. The pipe is built
// from the 16-stage log2 squaring pipe on lux and max_level and the 16-stage
// exp2 product chain of the gamma step, plus 9 stages of curve, scaling and
// rounding. All stages advance together; out_stall_i holds the whole pipe.
// Registers are written by index: 0 max_screen_nit, 1 max_level; write them
// only while no item is in flight.
module ambient_light_backlight_level_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [albl_pkg::LUX_W-1:0]    lux_i,
  input  logic signed [albl_pkg::ADJ_W-1:0] user_adjust_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    level_o,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [albl_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int NSTG = 1 + albl_pkg::LOG_STEPS + 4 + 2 + albl_pkg::PWR_STEPS + 2;

  logic [albl_pkg::NIT_W-1:0] nit_q;
  logic [albl_pkg::ML_W-1:0]  ml_q;
  logic [NSTG-1:0]            vld_q;
  logic                       en;

  // ---- configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nit_q <= albl_pkg::RST_MAX_NIT;
      ml_q  <= albl_pkg::RST_MAX_LEVEL;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        albl_pkg::CFG_MAX_NIT:   nit_q <= cfg_data_i[albl_pkg::NIT_W-1:0];
        albl_pkg::CFG_MAX_LEVEL: ml_q  <= cfg_data_i[albl_pkg::ML_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- global advance: hold everything while the result waits
  assign in_stall_o = vld_q[NSTG-1] & out_stall_i;
  assign en         = ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // ---- stage 0: normalize lux and max_level, saturate the bias
  logic [3:0]                  lux_top, ml_top;
  logic [32:0]                 lux_sh;
  logic [27:0]                 ml_sh;
  logic signed [albl_pkg::ADJ_W-1:0] adj_sat;
  logic signed [19:0]          e_s;
  albl_pkg::side_t             s0_d, s0_q;
  logic [albl_pkg::FRAC_W:0]   mlux_q, mml_q;

  always_comb begin
    lux_top = 4'd0;
    ml_top  = 4'd0;
    for (int b = 0; b < albl_pkg::LUX_W; b++) begin
      if (lux_i[b]) lux_top = 4'(b);
    end
    for (int b = 0; b < albl_pkg::ML_W; b++) begin
      if (ml_q[b]) ml_top = 4'(b);
    end
    lux_sh = 33'(lux_i) << (5'd16 - 5'(lux_top));
    ml_sh  = 28'(ml_q) << (5'd16 - 5'(ml_top));

    if (user_adjust_i > $signed(9'(1 << albl_pkg::ADJ_FRAC))) begin
      adj_sat = 9'(1 << albl_pkg::ADJ_FRAC);
    end else if (user_adjust_i < -$signed(9'(1 << albl_pkg::ADJ_FRAC))) begin
      adj_sat = -$signed(9'(1 << albl_pkg::ADJ_FRAC));
    end else begin
      adj_sat = user_adjust_i;
    end
    e_s = 20'sd196608 - (20'(adj_sat) <<< (16 - albl_pkg::ADJ_FRAC));

    s0_d.byp     = (lux_i == '0) || (ml_q == '0);
    s0_d.lev     = 8'd1;
    s0_d.e       = e_s[albl_pkg::EXP_W-1:0];
    s0_d.lux_top = lux_top;
    s0_d.ml_top  = ml_top;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q   <= s0_d;
      mlux_q <= lux_sh[16:0];
      mml_q  <= ml_sh[16:0];
    end
  end

  // ---- stages 1..16: log2 fraction of both values
  logic [albl_pkg::FRAC_W-1:0] flux, fml;
  albl_pkg::side_t             sb_q [albl_pkg::LOG_STEPS];

  albl_log2_pipe u_log_lux (.clk_i(clk_i), .en_i(en), .m_i(mlux_q), .frac_o(flux));
  albl_log2_pipe u_log_ml  (.clk_i(clk_i), .en_i(en), .m_i(mml_q),  .frac_o(fml));

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= s0_q;
      for (int k = 1; k < albl_pkg::LOG_STEPS; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  albl_pkg::side_t sl;
  logic [albl_pkg::LOG_W-1:0] llux, lml;
  assign sl   = sb_q[albl_pkg::LOG_STEPS-1];
  assign llux = {sl.lux_top, flux};
  assign lml  = {sl.ml_top, fml};

  // ---- curve: C1*L + C0, times nits, times 17, round and divide by 2000
  logic [39:0]  c1_q;
  logic [53:0]  c2_q;
  logic [30:0]  c3_t_q;
  logic         c3_sat_q;
  logic [albl_pkg::LOG_W-1:0] lml1_q, lml2_q, lml3_q;
  logic [albl_pkg::EXP_W-1:0] e1_q, e2_q, e3_q, e4_q;
  logic         byp1_q, byp2_q, byp3_q, byp4_q;
  logic [7:0]   lev1_q, lev2_q, lev3_q, lev4_q;
  logic [58:0]  num;
  logic [59:0]  rsum;
  logic [27:0]  q;

  assign num  = {c2_q, 4'b0} + 59'(c2_q);
  assign rsum = 60'(num) + (60'd1000 << 32);
  assign q    = rsum[59:32];

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q     <= albl_pkg::CURVE_C1 * 40'(llux) + (albl_pkg::CURVE_C0 << 16);
      c2_q     <= 54'(c1_q) * 54'(nit_q);
      c3_sat_q <= (q >= albl_pkg::SAT_Q);
      c3_t_q   <= 31'(q[18:4]) * albl_pkg::RECIP;
      lml1_q <= lml;     lml2_q <= lml1_q;  lml3_q <= lml2_q;
      e1_q   <= sl.e;    e2_q   <= e1_q;    e3_q   <= e2_q;    e4_q <= e3_q;
      byp1_q <= sl.byp;  byp2_q <= byp1_q;  byp3_q <= byp2_q;
      lev1_q <= sl.lev;  lev2_q <= lev1_q;  lev3_q <= lev2_q;
    end
  end

  // ---- first level, its log, the ratio exponent
  logic [8:0]  r1_raw;
  logic [7:0]  r1;
  logic signed [albl_pkg::LOG_W:0] dd;
  logic [albl_pkg::LOG_W-1:0] d_q;
  logic        ge_ml;

  always_comb begin
    r1_raw = c3_t_q[30:albl_pkg::RECIP_SH];
    if (c3_sat_q) r1 = 8'd255;
    else if (r1_raw == 9'd0) r1 = 8'd1;
    else r1 = r1_raw[7:0];
    ge_ml = (12'(r1) >= ml_q);
    dd    = $signed({1'b0, lml3_q}) - $signed({1'b0, albl_pkg::LOG_LUT[r1]});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q <= dd[albl_pkg::LOG_W] ? '0 : dd[albl_pkg::LOG_W-1:0];
      // first level at or above max_level: level is max_level, clamped
      if (!byp3_q && ge_ml) begin
        byp4_q <= 1'b1;
        lev4_q <= (ml_q > 12'd255) ? 8'd255 : ml_q[7:0];
      end else begin
        byp4_q <= byp3_q;
        lev4_q <= lev3_q;
      end
    end
  end

  // ---- p = e*d, then integer and fractional parts of the power
  logic [38:0] pp;
  logic [22:0] p_q;
  logic        bypp_q;
  logic [7:0]  levp_q;
  logic [23:0] pn;
  logic [22:0] gfull;
  albl_pkg::pwr_t pw_q [albl_pkg::PWR_STEPS+1];

  assign pp    = 39'(e4_q) * 39'(d_q);
  assign pn    = 24'(p_q) + 24'd65535;
  assign gfull = {pn[22:16], 16'b0} - p_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q    <= pp[38:16];
      bypp_q <= byp4_q;
      levp_q <= lev4_q;
      pw_q[0].byp <= bypp_q;
      pw_q[0].lev <= levp_q;
      pw_q[0].n   <= pn[22:16];
      pw_q[0].g   <= gfull[15:0];
      pw_q[0].acc <= 31'h4000_0000;
    end
  end

  // ---- exp2 of the fraction: one root factor per stage, high bit first
  for (genvar k = 1; k <= albl_pkg::PWR_STEPS; k++) begin : g_pwr
    logic [62:0]    prod;
    albl_pkg::pwr_t pw_d;
    assign prod = 63'(pw_q[k-1].acc) * 63'(albl_pkg::FTAB[k]);
    always_comb begin
      pw_d = pw_q[k-1];
      if (pw_q[k-1].g[albl_pkg::PWR_STEPS-k]) pw_d.acc = prod[60:30];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        pw_q[k] <= pw_d;
      end
    end
  end

  // ---- scale by max_level, round, shift by 30+n, clamp
  albl_pkg::pwr_t pl;
  logic [42:0] m1_q;
  logic [6:0]  n1_q;
  logic        bypm_q;
  logic [7:0]  levm_q;
  logic [63:0] fsum, fval;
  logic [7:0]  lev_d;
  logic [7:0]  level_q;

  assign pl = pw_q[albl_pkg::PWR_STEPS];

  always_comb begin
    fsum = 64'(m1_q) + (64'd1 << (7'd29 + n1_q));
    fval = fsum >> (7'd30 + n1_q);
    if (bypm_q) lev_d = levm_q;
    else if (n1_q > 7'd32 || fval == 64'd0) lev_d = 8'd1;
    else if (fval > 64'd255) lev_d = 8'd255;
    else lev_d = fval[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q    <= 43'(ml_q) * 43'(pl.acc);
      n1_q    <= pl.n;
      bypm_q  <= pl.byp;
      levm_q  <= pl.lev;
      level_q <= lev_d;
    end
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign level_o     = level_q;

endmodule

[test/ambient_light_backlight_level_top_tb.sv]
// ----------------------------------------------------------------------------
// ambient_light_backlight_level_top_tb - self-checking bench for the backlight
// level block
// Drives lux and user bias items against several register settings, predicts
// each level with an independent fixed-point model of the curve and gamma step,
// and compares every accepted level in order. Both handshake sides idle and
// stall at random.
// ----------------------------------------------------------------------------
class level_scoreboard;
  logic [7:0]          level_q[$];
  logic [13:0]         peak_nit;
  logic [11:0]         panel_max;
  longint unsigned     root_f[17];
  int                  errors;
  int                  items_in;
  int                  levels_out;

  function new();
    longint unsigned lo, hi, mid, v;
    peak_nit  = albl_pkg::RST_MAX_NIT;
    panel_max = albl_pkg::RST_MAX_LEVEL;
    errors    = 0;
    items_in  = 0;
    levels_out = 0;
    // successive square roots of 2 in Q30, found by bisection
    root_f[0] = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      v  = root_f[k-1] << 30;
      lo = 0;
      hi = 64'd1 << 32;
      while (hi - lo > 1) begin
        mid = (lo + hi) >> 1;
        if (mid * mid <= v) lo = mid;
        else hi = mid;
      end
      root_f[k] = lo;
    end
  endfunction

  function longint unsigned log2_fix(longint unsigned x);
    int              top;
    longint unsigned m, fr;
    top = 0;
    fr  = 0;
    for (int b = 0; b < 64; b++) begin
      if ((x >> b) != 0) top = b;
    end
    m = (top >= 16) ? (x >> (top - 16)) : (x << (16 - top));
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 16;
      if (m >= (64'd2 << 16)) begin
        m = m >> 1;
        fr = fr | (64'd1 << i);
      end
    end
    return (longint'(top) << 16) | fr;
  endfunction

  function logic [7:0] sat_level(longint unsigned v);
    if (v < 1) return 8'd1;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function logic [7:0] backlight_level(logic [15:0] lux, logic signed [8:0] bias);
    longint          a, e, d;
    longint unsigned num, r1, p, n, g, acc, lev;
    a = bias;
    if (a > 128) a = 128;
    if (a < -128) a = -128;
    if (lux == 0 || panel_max == 0) return 8'd1;
    num = (64'd451186 * log2_fix(lux) + (64'd1773339 << 16)) * peak_nit * 17;
    r1  = sat_level((num + (64'd1000 << 32)) / (64'd2000 << 32));
    if (r1 >= panel_max) return sat_level(panel_max);
    e = (longint'(3) << 16) - a * 512;
    d = longint'(log2_fix(panel_max)) - longint'(log2_fix(r1));
    if (d < 0) d = 0;
    p = (longint'(e) * longint'(d)) >> 16;
    n = (p + 65535) >> 16;
    g = (n << 16) - p;
    acc = 64'd1 << 30;
    for (int k = 1; k <= 16; k++) begin
      if (g[16-k]) acc = (acc * root_f[k]) >> 30;
    end
    if (30 + n > 62) lev = 0;
    else lev = (panel_max * acc + (64'd1 << (29 + n))) >> (30 + n);
    return sat_level(lev);
  endfunction

  function void note_item(logic [15:0] lux, logic signed [8:0] bias);
    level_q.push_back(backlight_level(lux, bias));
    items_in++;
  endfunction

  function void check_level(logic [7:0] got);
    logic [7:0] want;
    levels_out++;
    if (level_q.size() == 0) begin
      $error("level: unexpected result %0d with nothing pending", got);
      errors++;
      return;
    end
    want = level_q.pop_front();
    if (got !== want) begin
      $error("level: expected %0d, actual %0d", want, got);
      errors++;
    end
  endfunction
endclass

module ambient_light_backlight_level_top_tb;

  localparam int LIMIT = 2000000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [albl_pkg::LUX_W-1:0]        lux_i = '0;
  logic signed [albl_pkg::ADJ_W-1:0] user_adjust_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [7:0]              level_o;
  logic                    cfg_we_i = 1'b0;
  logic [0:0]              cfg_idx_i = albl_pkg::CFG_MAX_NIT;
  logic [albl_pkg::CFG_W-1:0]        cfg_data_i = '0;

  level_scoreboard sb = new();
  int  cycles = 0;
  bit  calm = 1'b0;      // stretch with no idling on either side
  int  stall_pct = 30;

  ambient_light_backlight_level_top u_dut (.*);

  always #10 clk_i = ~clk_i;

  // watch both handshakes at the rising edge
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_item(lux_i, user_adjust_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_level(level_o);
  end

  // receiver back-pressure: mostly short stalls, now and then a long one
  always @(negedge clk_i) begin
    if (calm) out_stall_i <= 1'b0;
    else if ($urandom_range(0, 999) < 3) out_stall_i <= 1'b1;
    else if (out_stall_i && $urandom_range(0, 99) < 90 && $urandom_range(0, 99) < 95)
      out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // hold the item until the block takes it, then idle for a random gap
  task automatic send_item(logic [15:0] lux, logic signed [8:0] bias);
    int gap;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    lux_i         <= lux;
    user_adjust_i <= bias;
    do @(posedge clk_i); while (in_stall_o);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // wait out every pending level, then the pipe depth
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (sb.level_q.size() == 0);
    repeat (50) @(posedge clk_i);
  endtask

  // empty the pipe first, then write both registers
  task automatic set_regs(logic [13:0] nit, logic [11:0] lvl);
    drain();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= albl_pkg::CFG_MAX_NIT;
    cfg_data_i <= nit;
    @(negedge clk_i);
    cfg_idx_i  <= albl_pkg::CFG_MAX_LEVEL;
    cfg_data_i <= albl_pkg::CFG_W'(lvl);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.peak_nit  = nit;
    sb.panel_max = lvl;
  endtask

  function automatic logic [15:0] rand_lux();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'd0;
    if (r < 10) return 16'hFFFF;
    if (r < 55) return 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic signed [8:0] rand_bias();
    if ($urandom_range(0, 99) < 80) return 9'(int'($urandom_range(0, 256)) - 128);
    return 9'($urandom_range(0, 511));
  endfunction

  logic [13:0] nit_set[8] = '{14'd400, 14'd1, 14'd10000, 14'd16383,
                              14'd0, 14'd5000, 14'd250, 14'd800};
  logic [11:0] lvl_set[8] = '{12'd255, 12'd4095, 12'd4095, 12'd1,
                              12'd255, 12'd0, 12'd1000, 12'd100};
  logic [15:0] lux_dir[8] = '{16'd0, 16'd1, 16'd2, 16'd3,
                              16'd255, 16'd32768, 16'd65535, 16'd1000};
  logic signed [8:0] bias_dir[8] = '{-9'sd256, 9'sd255, -9'sd128, 9'sd128,
                                     9'sd0, -9'sd129, 9'sd129, 9'sd1};

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes and bias saturation at reset settings
    calm = 1'b1;
    for (int i = 0; i < 8; i++) send_item(lux_dir[i], bias_dir[i]);
    calm = 1'b0;
    for (int i = 0; i < 8; i++) send_item(lux_dir[7 - i], bias_dir[i]);
    drain();
    // first level above max_level, then zero max_level
    set_regs(14'd10000, 12'd10);
    send_item(16'd65535, 9'sd0);
    send_item(16'd1, -9'sd128);
    set_regs(14'd400, 12'd0);
    send_item(16'd500, 9'sd64);
    send_item(16'd0, 9'sd64);
    drain();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 8) set_regs(nit_set[ph], lvl_set[ph]);
      else set_regs(14'($urandom_range(0, 16383)), 12'($urandom_range(0, 4095)));
      stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 60);
      calm = (ph == 2);
      for (int i = 0; i < 160; i++) begin
        send_item(rand_lux(), rand_bias());
        if (ph == 4 && i == 80) begin
          // let the pipe run dry mid-phase before sending more
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          wait (sb.level_q.size() == 0);
        end
      end
      calm = 1'b0;
      drain();
    end

    repeat (60) @(posedge clk_i);
    if (sb.level_q.size() != 0) begin
      $error("level: %0d expected results never arrived", sb.level_q.size());
      sb.errors++;
    end
    $display("Covered %0d items and %0d levels over twelve register settings,",
             sb.items_in, sb.levels_out);
    $display("with zero lux, zero registers, bias saturation and random stalls.");
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
